@@ design/utf8_decoder_with_lookalike_fold_defines.svh @@
// ----------------------------------------------------------------------------
// utf8 decoder assertion macros
// shared concurrent assertion forms, clocked on clk, quiet while rst_n is low
// ----------------------------------------------------------------------------
`ifndef UTF8_DECODER_WITH_LOOKALIKE_FOLD_DEFINES_SVH
`define UTF8_DECODER_WITH_LOOKALIKE_FOLD_DEFINES_SVH

// condition holds at every edge out of reset
`define UTF8LF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define UTF8LF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence holds in the cycle after the antecedent
`define UTF8LF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/utf8lf_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8lf_pkg
// shared types, state codes and the lookalike fold table
// ----------------------------------------------------------------------------
package utf8lf_pkg;

  // continuation bytes still expected
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  // lead byte prefixes
  localparam logic [2:0] LEAD2_PFX = 3'b110;
  localparam logic [3:0] LEAD3_PFX = 4'b1110;

  // decode result for one word, handed to the top level
  typedef struct packed {
    logic        emit;
    logic [15:0] code_unit;
    logic [1:0]  pending_nxt;
    logic [9:0]  partial_nxt;
  } dec_res_t;

  // map lookalike characters onto their latin forms
  function automatic logic [15:0] fold_unit(input logic [15:0] c);
    logic [15:0] f;
    case (c)
      16'h0410: f = 16'h0041;
      16'h0412: f = 16'h0042;
      16'h0415: f = 16'h0045;
      16'h041A: f = 16'h004B;
      16'h041C: f = 16'h004D;
      16'h041D: f = 16'h0048;
      16'h041E: f = 16'h004F;
      16'h0420: f = 16'h0050;
      16'h0421: f = 16'h0043;
      16'h0422: f = 16'h0054;
      16'h0425: f = 16'h0058;
      16'h043E: f = 16'h006F;
      16'h00BA: f = 16'h006F;
      16'h0440: f = 16'h0070;
      16'h0441: f = 16'h0063;
      16'h0445: f = 16'h0078;
      16'h0435: f = 16'h0065;
      16'h0430: f = 16'h0061;
      16'h00AA: f = 16'h0061;
      16'h0060: f = 16'h0027;
      default:  f = c;
    endcase
    return f;
  endfunction

endpackage

@@ design/utf8lf_decode.sv @@
// ----------------------------------------------------------------------------
// utf8lf_decode
// one step of the utf-8 sequence decoder plus lookalike fold
// ----------------------------------------------------------------------------
module utf8lf_decode
  import utf8lf_pkg::*;
(
  input  logic [7:0] byte_in,
  input  logic       last_byte,
  input  logic [1:0] pending,
  input  logic [9:0] partial,
  output dec_res_t   res
);

  logic [15:0] acc;
  logic [15:0] unit;
  logic        done;
  logic [1:0]  pend_n;
  logic [9:0]  part_n;

  // gathered bits with this word's low six bits appended
  assign acc = {partial, byte_in[5:0]};

  // sequence step
  always_comb begin
    unit   = {8'h00, byte_in};
    done   = 1'b0;
    pend_n = PEND_NONE;
    part_n = 10'd0;
    case (pending)
      PEND_ONE: begin
        unit = acc;
        done = 1'b1;
      end
      PEND_TWO: begin
        part_n = acc[9:0];
        pend_n = PEND_ONE;
        unit   = {acc[9:0], 6'b000000};
      end
      default: begin
        if (byte_in[7:5] == LEAD2_PFX) begin
          part_n = {5'b00000, byte_in[4:0]};
          pend_n = PEND_ONE;
          unit   = {5'b00000, byte_in[4:0], 6'b000000};
        end else if (byte_in[7:4] == LEAD3_PFX) begin
          part_n = {6'b000000, byte_in[3:0]};
          pend_n = PEND_TWO;
          unit   = {byte_in[3:0], 12'h000};
        end else begin
          done = 1'b1;
        end
      end
    endcase
  end

  // a finished or truncated unit goes out and the decoder returns to ground
  always_comb begin
    res.emit        = done | last_byte;
    res.code_unit   = fold_unit(unit);
    res.pending_nxt = res.emit ? PEND_NONE : pend_n;
    res.partial_nxt = res.emit ? 10'd0 : part_n;
  end

endmodule

@@ design/utf8_decoder_with_lookalike_fold.sv @@
// ----------------------------------------------------------------------------
// utf8_decoder_with_lookalike_fold
// utf-8 byte stream to 16-bit code units, with lookalike characters folded
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_stall, in_byte_in,         | in
//          | in_last_byte                            |
//  out     | out_valid, out_stall, out_code_unit,    | out
//          | out_last_unit                           |
//
//  one word a cycle while in_stall is low; a unit reaches the output after its final
//  byte is taken (input register, then decode and fold into the result register)
//  rst_n is synchronous and returns the decoder to the ground state
//  out_stall holds the result register; in_stall rises only when the input
//  register is full and the result register cannot take a new unit
// ----------------------------------------------------------------------------
`include "utf8_decoder_with_lookalike_fold_defines.svh"

module utf8_decoder_with_lookalike_fold
  import utf8lf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_in,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code_unit,
  output logic        out_last_unit
);

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic [1:0]  pending_r, pending_nxt;
  logic [9:0]  partial_r, partial_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_code_r;
  logic        out_last_r;
  logic        in_acc;
  logic        s2_free;
  logic        advance;
  dec_res_t    dec;

  // handshake control
  assign s2_free  = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && s2_free;
  assign in_stall = s1_valid_r && !s2_free;
  assign in_acc   = in_valid && !in_stall;

  // decode and fold
  utf8lf_decode u_decode (
    .byte_in   (s1_byte_r),
    .last_byte (s1_last_r),
    .pending   (pending_r),
    .partial   (partial_r),
    .res       (dec)
  );

  // next control state
  always_comb begin
    s1_valid_nxt  = in_acc || (s1_valid_r && !advance);
    pending_nxt   = advance ? dec.pending_nxt : pending_r;
    partial_nxt   = advance ? dec.partial_nxt : partial_r;
    out_valid_nxt = advance ? dec.emit : (out_valid_r && out_stall);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      pending_r   <= PEND_NONE;
      partial_r   <= 10'd0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      pending_r   <= pending_nxt;
      partial_r   <= partial_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input word register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_byte_in;
      s1_last_r <= in_last_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance && dec.emit) begin
      out_code_r <= dec.code_unit;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_code_unit = out_code_r;
  assign out_last_unit = out_last_r;

  // checks
  `UTF8LF_ASSERT_SAME(a_stall_needs_word, in_stall, s1_valid_r, "in_stall with empty input register")
  `UTF8LF_ASSERT_SAME(a_ground_clean, pending_r == PEND_NONE, partial_r == 10'd0, "stale partial bits in ground state")
  `UTF8LF_ASSERT_NEXT(a_last_resets, advance && s1_last_r, pending_r == PEND_NONE && out_valid_r, "last word left a sequence open")
  `UTF8LF_ASSERT_NEXT(a_one_left_emits, advance && pending_r == PEND_ONE, out_valid_r && pending_r == PEND_NONE, "final continuation gave no unit")
  `UTF8LF_ASSERT_NEXT(a_held_result, out_valid_r && out_stall, out_valid_r && $stable(out_code_r), "stalled result lost")

endmodule
